// ----- sv/irt_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// irt_pkg - interval reservation table shared definitions
// Field widths, operation codes, FSM states and the control/status bundles
// passed between the controller and the datapath.
// ---------------------------------------------------------------------------
package irt_pkg;

  localparam int OP_W    = 2;
  localparam int RES_W   = 16;
  localparam int TICK_W  = 32;
  localparam int ID_W    = 32;
  localparam int COUNT_W = 7;

  localparam logic [ID_W-1:0] ID_FIRST = 32'h0000_0001;
  localparam logic [ID_W-1:0] ID_LAST  = 32'hFFFF_FFFF;

  typedef enum logic [OP_W-1:0] {
    OP_BOOK   = 2'd0,
    OP_CANCEL = 2'd1,
    OP_CHECK  = 2'd2,
    OP_COUNT  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DECIDE,
    ST_MOVE_RD,
    ST_MOVE_WR,
    ST_FINISH
  } state_t;

  // One stored reservation.
  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [RES_W-1:0]  resource;
    logic [TICK_W-1:0] win_lo;
    logic [TICK_W-1:0] win_hi;
  } entry_t;

  // Controller -> datapath commands.
  typedef struct packed {
    logic load;      // latch request, clear scan accumulators
    logic issue;     // read next table entry during scan
    logic decide;    // resolve op, book write
    logic move_rd;   // read last entry for cancel
    logic move_wr;   // write last entry into freed slot
    logic finish;    // load output register
  } irt_cmd_t;

  // Datapath -> controller status.
  typedef struct packed {
    op_t  op;
    logic total_zero;
    logic issue_last;
    logic found;
    logic out_busy;
  } irt_sts_t;

endpackage

// ----- sv/irt_ctrl.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// irt_ctrl - interval reservation table controller
// Sequences scan, decision, cancel move and result transfer.
// ---------------------------------------------------------------------------
module irt_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  irt_pkg::irt_sts_t  sts,
  output irt_pkg::irt_cmd_t  cmd
);
  import irt_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (sts.total_zero) begin
          state_nxt = ST_DECIDE;
        end else begin
          cmd.issue = 1'b1;
          if (sts.issue_last) begin
            state_nxt = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        cmd.decide = 1'b1;
        if (sts.op == OP_CANCEL && sts.found) begin
          state_nxt = ST_MOVE_RD;
        end else begin
          state_nxt = ST_FINISH;
        end
      end
      ST_MOVE_RD: begin
        cmd.move_rd = 1'b1;
        state_nxt   = ST_MOVE_WR;
      end
      ST_MOVE_WR: begin
        cmd.move_wr = 1'b1;
        state_nxt   = ST_FINISH;
      end
      ST_FINISH: begin
        if (!sts.out_busy) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- sv/irt_dp.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// irt_dp - interval reservation table datapath
// Entry memory, scan comparator, counters and the output register.
// ---------------------------------------------------------------------------
module irt_dp #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  irt_pkg::irt_cmd_t             cmd,
  output irt_pkg::irt_sts_t             sts,
  input  logic [irt_pkg::OP_W-1:0]      in_operation,
  input  logic [irt_pkg::RES_W-1:0]     in_resource,
  input  logic [irt_pkg::TICK_W-1:0]    in_window_start,
  input  logic [irt_pkg::TICK_W-1:0]    in_window_end,
  input  logic [irt_pkg::ID_W-1:0]      in_cancel_id,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_success,
  output logic [irt_pkg::ID_W-1:0]      out_new_id,
  output logic [irt_pkg::COUNT_W-1:0]   out_resource_count,
  output logic [irt_pkg::COUNT_W-1:0]   out_active_count
);
  import irt_pkg::*;

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(TABLE_DEPTH);
  localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

  // Entry memory
  entry_t mem [TABLE_DEPTH];

  // Request
  op_t               op_r;
  logic [RES_W-1:0]  res_r;
  logic [TICK_W-1:0] lo_r;
  logic [TICK_W-1:0] hi_r;
  logic [ID_W-1:0]   cid_r;

  // Table control state
  logic [CNT_W-1:0]  total_r, total_nxt;
  logic [ID_W-1:0]   id_ctr_r, id_ctr_nxt;

  // Scan
  logic [IDX_W-1:0]  scan_addr_r;
  logic [IDX_W-1:0]  rd_idx_r;
  logic              rd_valid_r;
  entry_t            rd_data_r;
  logic              conflict_r;
  logic              found_r;
  logic [IDX_W-1:0]  found_idx_r;
  logic [CNT_W-1:0]  rcount_r;

  // Decision
  logic              res_ok_r;
  logic [ID_W-1:0]   res_id_r;

  // Output register
  logic              out_valid_r;
  logic              out_success_r;
  logic [ID_W-1:0]   out_new_id_r;
  logic [COUNT_W-1:0] out_rcount_r;
  logic [COUNT_W-1:0] out_total_r;

  logic [IDX_W-1:0]  last_idx;
  logic [IDX_W-1:0]  total_idx;
  logic              book_ok;
  logic              hit_res;
  logic              overlap;
  logic              rd_en;
  logic [IDX_W-1:0]  rd_addr;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  entry_t            wr_data;
  logic [CNT_W+COUNT_W-1:0] rcount_ext;
  logic [CNT_W+COUNT_W-1:0] total_ext;

  assign last_idx  = IDX_W'(total_r - CNT_ONE);
  assign total_idx = IDX_W'(total_r);
  assign book_ok   = (hi_r > lo_r) && (total_r != CNT_FULL) && !conflict_r;
  assign hit_res   = rd_data_r.resource == res_r;
  assign overlap   = (lo_r < rd_data_r.win_hi) && (rd_data_r.win_lo < hi_r);

  assign rd_en   = cmd.issue | cmd.move_rd;
  assign rd_addr = cmd.move_rd ? last_idx : scan_addr_r;
  assign wr_en   = (cmd.decide && op_r == OP_BOOK && book_ok) | cmd.move_wr;
  assign wr_addr = cmd.move_wr ? found_idx_r : total_idx;
  always_comb begin
    if (cmd.move_wr) begin
      wr_data = rd_data_r;
    end else begin
      wr_data.id       = id_ctr_r;
      wr_data.resource = res_r;
      wr_data.win_lo   = lo_r;
      wr_data.win_hi   = hi_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // Count and id updates
  always_comb begin
    total_nxt  = total_r;
    id_ctr_nxt = id_ctr_r;
    if (cmd.decide && op_r == OP_BOOK && book_ok) begin
      total_nxt  = total_r + CNT_ONE;
      id_ctr_nxt = (id_ctr_r == ID_LAST) ? ID_FIRST : id_ctr_r + ID_FIRST;
    end else if (cmd.move_wr) begin
      total_nxt = total_r - CNT_ONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r     <= '0;
      id_ctr_r    <= ID_FIRST;
      rd_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      total_r    <= total_nxt;
      id_ctr_r   <= id_ctr_nxt;
      rd_valid_r <= cmd.issue;
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Request latch, scan accumulation, decision
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r        <= op_t'(in_operation);
      res_r       <= in_resource;
      lo_r        <= in_window_start;
      hi_r        <= in_window_end;
      cid_r       <= in_cancel_id;
      scan_addr_r <= '0;
      conflict_r  <= 1'b0;
      found_r     <= 1'b0;
      found_idx_r <= '0;
      rcount_r    <= '0;
    end else begin
      if (cmd.issue) begin
        scan_addr_r <= scan_addr_r + IDX_W'(1);
      end
      if (rd_valid_r) begin
        if (hit_res && overlap) begin
          conflict_r <= 1'b1;
        end
        if (hit_res) begin
          rcount_r <= rcount_r + CNT_ONE;
        end
        if (rd_data_r.id == cid_r && !found_r) begin
          found_r     <= 1'b1;
          found_idx_r <= rd_idx_r;
        end
      end
    end
    if (cmd.issue) begin
      rd_idx_r <= scan_addr_r;
    end
    if (cmd.decide) begin
      res_id_r <= (op_r == OP_BOOK && book_ok) ? id_ctr_r : '0;
      unique case (op_r)
        OP_BOOK:   res_ok_r <= book_ok;
        OP_CANCEL: res_ok_r <= found_r;
        OP_CHECK:  res_ok_r <= !conflict_r;
        OP_COUNT:  res_ok_r <= 1'b1;
        default:   res_ok_r <= 1'b0;
      endcase
    end
  end

  assign rcount_ext = {{COUNT_W{1'b0}}, rcount_r};
  assign total_ext  = {{COUNT_W{1'b0}}, total_r};

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_success_r <= res_ok_r;
      out_new_id_r  <= res_id_r;
      out_rcount_r  <= (op_r == OP_COUNT) ? rcount_ext[COUNT_W-1:0] : '0;
      out_total_r   <= total_ext[COUNT_W-1:0];
    end
  end

  assign out_valid          = out_valid_r;
  assign out_success        = out_success_r;
  assign out_new_id         = out_new_id_r;
  assign out_resource_count = out_rcount_r;
  assign out_active_count   = out_total_r;

  assign sts.op         = op_r;
  assign sts.total_zero = (total_r == '0);
  assign sts.issue_last = (scan_addr_r == last_idx);
  assign sts.found      = found_r;
  assign sts.out_busy   = out_valid_r && !out_ready;

endmodule

// ----- sv/interval_reservation_table.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// interval_reservation_table - reservation table with overlap checking
// Books, cancels, checks and counts half-open intervals per resource.
// ---------------------------------------------------------------------------
// Holds up to TABLE_DEPTH reservations (id, resource, [start, end)) in a
// single-port-read / single-port-write memory. Every request is one transfer
// in and exactly one transfer out. Each request is accepted, then scans the
// active entries through one comparator, one entry per cycle, then drains
// the read pipeline, decides and loads the result into the output register;
// a cancel that finds its id also reads the last entry and then writes it
// into the slot that the cancelled entry freed.
// One request is in flight at a time; the next one can be accepted while
// the previous result still sits unread in the output register. Ids start
// at 1 and wrap from 0xFFFFFFFF back to 1. No clearing pass is needed after
// reset: only entries below the active count are ever read.
// ---------------------------------------------------------------------------
module interval_reservation_table #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // request channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [irt_pkg::OP_W-1:0]      in_operation,
  input  logic [irt_pkg::RES_W-1:0]     in_resource,
  input  logic [irt_pkg::TICK_W-1:0]    in_window_start,
  input  logic [irt_pkg::TICK_W-1:0]    in_window_end,
  input  logic [irt_pkg::ID_W-1:0]      in_cancel_id,
  // result channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_success,
  output logic [irt_pkg::ID_W-1:0]      out_new_id,
  output logic [irt_pkg::COUNT_W-1:0]   out_resource_count,
  output logic [irt_pkg::COUNT_W-1:0]   out_active_count
);
  import irt_pkg::*;

  irt_cmd_t cmd;
  irt_sts_t sts;

  // FSM: idle -> scan -> (drain) -> decide -> (move) -> finish
  irt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Entry memory, comparator, counters, output register
  irt_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_operation       (in_operation),
    .in_resource        (in_resource),
    .in_window_start    (in_window_start),
    .in_window_end      (in_window_end),
    .in_cancel_id       (in_cancel_id),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_success        (out_success),
    .out_new_id         (out_new_id),
    .out_resource_count (out_resource_count),
    .out_active_count   (out_active_count)
  );

endmodule
